>>> hw/rtl/cansig_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cansig_pkg: shared types and constants for the CAN signal pack/unpack block
// Request and result items, request codes, status codes, queue entry type.
// ----------------------------------------------------------------------------
package cansig_pkg;

    localparam int FRAME_BYTES_DEF = 64;
    // The engine window is sized for signals of up to 32 bits
    localparam int MAX_SIGNAL_BITS = 32;

    // Request codes
    localparam logic [2:0] REQ_LOAD_BYTE = 3'd0;
    localparam logic [2:0] REQ_READ_U    = 3'd1;
    localparam logic [2:0] REQ_READ_S    = 3'd2;
    localparam logic [2:0] REQ_WRITE_U   = 3'd3;
    localparam logic [2:0] REQ_WRITE_S   = 3'd4;
    localparam logic [2:0] REQ_WRITE_F   = 3'd5;
    localparam logic [2:0] REQ_CLEAR     = 3'd6;
    localparam logic [2:0] REQ_READ_BYTE = 3'd7;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_VALUE = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [8:0]  start_bit;
        logic [5:0]  bit_length;
        logic        byte_order;
        logic [31:0] write_value;
        logic [5:0]  byte_index;
        logic [7:0]  byte_value;
    } req_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic [1:0]  status;
    } rsp_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic [2:0]  req_type;
        logic [1:0]  status;     // pre-decided status (range / value)
        logic [8:0]  start_bit;
        logic [5:0]  bit_length;
        logic        byte_order;
        logic [31:0] write_value;
        logic [5:0]  byte_index;
        logic [7:0]  byte_value;
    } cmd_t;

endpackage

>>> hw/rtl/cansig_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cansig_front: request classifier
// Checks geometry, value range and NaN, and hands a classified item on.
// ----------------------------------------------------------------------------
module cansig_front #(
    parameter int FRAME_BYTES = cansig_pkg::FRAME_BYTES_DEF
) (
    input  cansig_pkg::req_t req,
    output cansig_pkg::cmd_t cmd
);
    import cansig_pkg::*;

    logic        len_bad;
    logic        geo_bad;
    logic [5:0]  first_byte;
    logic [9:0]  last_pos;
    logic [6:0]  last_byte;
    logic [6:0]  span;
    logic        idx_bad;
    logic        nan;
    logic        val_bad;
    logic [63:0] lenmask;
    logic [63:0] sv_ext;
    logic [63:0] hi_chk;
    logic        is_sig;

    // Check signal geometry
    always_comb
    begin
        len_bad    = (req.bit_length == 6'd0) || (32'(req.bit_length) > MAX_SIGNAL_BITS);
        first_byte = req.start_bit[8:3];
        last_pos   = 10'(req.start_bit) + 10'(req.bit_length) - 10'd1;
        last_byte  = last_pos[9:3];
        span       = last_byte - 7'(first_byte);
        if (req.byte_order == 1'b0)
        begin
            geo_bad = 32'(last_byte) >= FRAME_BYTES;
        end
        else
        begin
            // Mirrored walk: lowest byte is first - span
            geo_bad = (span > 7'(first_byte)) || (32'(first_byte) >= FRAME_BYTES);
        end
        geo_bad = geo_bad || len_bad;
        idx_bad = 32'(req.byte_index) >= FRAME_BYTES;
    end

    // Check value range
    always_comb
    begin
        lenmask = (64'd1 << req.bit_length) - 64'd1;
        nan     = (req.write_value[30:23] == 8'hFF) && (req.write_value[22:0] != 23'd0);
        sv_ext  = {{32{req.write_value[31]}}, req.write_value};
        // signed fits when bits above len-1 all equal the sign
        hi_chk  = sv_ext >> (req.bit_length - 6'd1);
        val_bad = 1'b0;
        unique case (req.req_type)
            REQ_WRITE_U: val_bad = {32'd0, req.write_value} > lenmask;
            REQ_WRITE_F: val_bad = nan || ({32'd0, req.write_value} > lenmask);
            REQ_WRITE_S: val_bad = (hi_chk != 64'd0) && (hi_chk != {64{1'b1}} >>
                                   (req.bit_length - 6'd1));
            default:     val_bad = 1'b0;
        endcase
    end

    // Assemble classified item
    always_comb
    begin
        is_sig = (req.req_type != REQ_LOAD_BYTE) && (req.req_type != REQ_READ_BYTE) &&
                 (req.req_type != REQ_CLEAR);
        cmd.req_type    = req.req_type;
        cmd.start_bit   = req.start_bit;
        cmd.bit_length  = req.bit_length;
        cmd.byte_order  = req.byte_order;
        cmd.write_value = req.write_value;
        cmd.byte_index  = req.byte_index;
        cmd.byte_value  = req.byte_value;
        if (!is_sig)
        begin
            cmd.status = (req.req_type != REQ_CLEAR && idx_bad) ? ST_RANGE : ST_OK;
        end
        else if (geo_bad)
        begin
            cmd.status = ST_RANGE;
        end
        else if (val_bad)
        begin
            cmd.status = ST_VALUE;
        end
        else
        begin
            cmd.status = ST_OK;
        end
    end

endmodule

>>> hw/rtl/cansig_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cansig_fifo: two-entry queue between front and back
// Lets the classifier and the payload engine stall independently.
// ----------------------------------------------------------------------------
module cansig_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_stall,
    input  cansig_pkg::cmd_t wr_data,
    output logic             rd_valid,
    input  logic             rd_take,
    output cansig_pkg::cmd_t rd_data
);
    import cansig_pkg::*;

    cmd_t       mem_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign wr_stall = cnt_reg == 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_take && rd_valid;

    // Advance pointers
    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push)
        else $error("queue push while full");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("queue count out of range");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count did not advance");
`endif

endmodule

>>> hw/rtl/cansig_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cansig_back: payload engine
// Reads a 5-byte window of the payload store, then extracts the signal or, for a
// write, merges it and writes the window back, one byte per cycle. Clear sweeps bytes.
// ----------------------------------------------------------------------------
module cansig_back #(
    parameter int FRAME_BYTES = cansig_pkg::FRAME_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_take,
    input  cansig_pkg::cmd_t cmd,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output cansig_pkg::rsp_t rsp
);
    import cansig_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);
    localparam int NW = 5;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_CALC  = 3'd2;
    localparam logic [2:0] S_WR    = 3'd3;
    localparam logic [2:0] S_CLR   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [7:0]      mem [FRAME_BYTES];
    logic [2:0]      state_reg, state_next;
    cmd_t            cmd_reg;
    logic [2:0]      k_reg, k_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic [8*NW-1:0] win_reg, win_next;
    logic [7:0]      rdata_reg;
    logic            rok_reg;
    rsp_t            rsp_reg, rsp_next;
    logic            rsp_valid_reg, rsp_valid_next;

    logic            rd_en, wr_en;
    logic [AW-1:0]   rd_addr, wr_addr;
    logic [7:0]      wr_data;
    logic [6:0]      fb;
    logic [6:0]      win_byte;
    logic [AW-1:0]   win_addr;
    logic            win_ok;
    logic [2:0]      rk_reg;
    logic [39:0]     shifted;
    logic [39:0]     mask40;
    logic [39:0]     merged;
    logic [31:0]     raw;
    logic [31:0]     ext;
    logic [63:0]     lm64;
    logic            is_rmw;

    // Byte k of the window: Intel first+k, Motorola first-k
    always_comb
    begin
        fb       = {1'b0, cmd_reg.start_bit[8:3]};
        win_byte = cmd_reg.byte_order ? (fb - 7'(k_reg)) : (fb + 7'(k_reg));
        win_ok   = (cmd_reg.byte_order ? (7'(k_reg) <= fb) : 1'b1) &&
                   (32'(win_byte) < FRAME_BYTES);
        win_addr = AW'(win_byte);
    end

    // Window extract and merge
    always_comb
    begin
        lm64    = (64'd1 << cmd_reg.bit_length) - 64'd1;
        shifted = win_reg >> cmd_reg.start_bit[2:0];
        raw     = shifted[31:0] & lm64[31:0];
        ext     = raw;
        if (raw[cmd_reg.bit_length[4:0] - 5'd1] && cmd_reg.bit_length < 6'd32)
        begin
            ext = raw | ~lm64[31:0];
        end
        mask40  = {8'd0, lm64[31:0]} << cmd_reg.start_bit[2:0];
        merged  = (win_reg & ~mask40) |
                  (({8'd0, cmd_reg.write_value} << cmd_reg.start_bit[2:0]) & mask40);
    end

    // Control
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        clr_next       = clr_reg;
        win_next       = win_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        cmd_take       = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = win_addr;
        wr_en          = 1'b0;
        wr_addr        = win_addr;
        wr_data        = merged[8*k_reg +: 8];
        is_rmw         = (cmd_reg.req_type == REQ_WRITE_U) || (cmd_reg.req_type == REQ_WRITE_S)
                         || (cmd_reg.req_type == REQ_WRITE_F);
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take   = 1'b1;
                    state_next = S_RD;
                    k_next     = 3'd0;
                    win_next   = '0;
                    clr_next   = '0;
                end
            end
            S_RD:
            begin
                // Load-byte and bad items finish directly; a byte read waits for its data
                if (cmd_reg.status != ST_OK)
                begin
                    state_next = S_DONE;
                end
                else if (cmd_reg.req_type == REQ_CLEAR)
                begin
                    state_next = S_CLR;
                end
                else if (cmd_reg.req_type == REQ_LOAD_BYTE)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = AW'(cmd_reg.byte_index);
                    wr_data    = cmd_reg.byte_value;
                    state_next = S_DONE;
                end
                else if (cmd_reg.req_type == REQ_READ_BYTE)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(cmd_reg.byte_index);
                    k_next     = 3'd0;
                    state_next = S_CALC;
                end
                else
                begin
                    // Issue window reads, one per cycle
                    rd_en  = win_ok;
                    k_next = k_reg + 3'd1;
                    if (k_reg == 3'(NW - 1))
                    begin
                        state_next = S_CALC;
                    end
                end
            end
            S_CALC:
            begin
                // Last read data lands this cycle
                state_next = S_WR;
                k_next     = 3'd0;
            end
            S_WR:
            begin
                if (is_rmw)
                begin
                    wr_en  = win_ok;
                    k_next = k_reg + 3'd1;
                    if (k_reg == 3'(NW - 1))
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CLR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = 8'd0;
                clr_next = clr_reg + AW'(1);
                if (32'(clr_reg) == FRAME_BYTES - 1)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_next.status = cmd_reg.status;
                    rsp_next.read_value = '0;
                    if (cmd_reg.status == ST_OK)
                    begin
                        if (cmd_reg.req_type == REQ_READ_U)
                        begin
                            rsp_next.read_value = raw;
                        end
                        else if (cmd_reg.req_type == REQ_READ_S)
                        begin
                            rsp_next.read_value = ext;
                        end
                        else if (cmd_reg.req_type == REQ_READ_BYTE)
                        begin
                            rsp_next.read_value = {24'd0, win_reg[7:0]};
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        // Capture returning read data into the window
        if (rok_reg)
        begin
            win_next[8*rk_reg +: 8] = rdata_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            k_reg         <= 3'd0;
            clr_reg       <= '0;
            rok_reg       <= 1'b0;
            rk_reg        <= 3'd0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            k_reg         <= k_next;
            clr_reg       <= clr_next;
            rok_reg       <= rd_en;
            rk_reg        <= k_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cmd_reg <= cmd;
        end
        win_reg <= win_next;
        rsp_reg <= rsp_next;
    end

    // Payload store: reset leaves it unknown, so a sweep clears it after reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> state_reg == S_IDLE)
        else $error("command taken while busy");
    a_no_rw: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !rd_en)
        else $error("read and write in one cycle");
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_stall |=> $stable(rsp_reg))
        else $error("result changed while stalled");
`endif

endmodule

>>> hw/rtl/can_signal_pack_unpack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_signal_pack_unpack: CAN FD payload signal access
// Byte load/read, clear, and Intel/Motorola signal read and write.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake         | Payload
// req     | in        | req_valid / stall | cansig_pkg::req_t
// rsp     | out       | rsp_valid / stall | cansig_pkg::rsp_t
//
// The payload store has one port, so a signal read or write moves the
// five-byte window a byte a cycle, reading it and, for a write, writing it back.
// Clear zeroes all FRAME_BYTES payload bytes. After reset a clearing pass runs
// in the engine; up to two items wait in the queue meanwhile. A two-entry queue
// parts the classifier from the engine; a stalled result holds in its output
// register.
// ----------------------------------------------------------------------------
module can_signal_pack_unpack #(
    parameter int FRAME_BYTES = cansig_pkg::FRAME_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  cansig_pkg::req_t req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output cansig_pkg::rsp_t rsp
);
    import cansig_pkg::*;

    cmd_t cmd_in;
    cmd_t cmd_q;
    cmd_t cmd_sel;
    logic q_valid;
    logic q_take;
    logic q_stall;
    logic init_reg, init_next;
    logic rsp_valid_int;
    logic drop_reg, drop_next;

    // Hold off input while the initial clear command is injected
    assign req_stall = q_stall || init_reg;
    assign init_next = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= 1'b1;
        end
        else
        begin
            init_reg <= init_next;
        end
    end

    cansig_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .req (req),
        .cmd (cmd_in)
    );

    cansig_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (req_valid && !init_reg),
        .wr_stall (q_stall),
        .wr_data  (cmd_in),
        .rd_valid (q_valid),
        .rd_take  (q_take && !init_reg),
        .rd_data  (cmd_q)
    );

    // Inject a clear command once after reset
    always_comb
    begin
        cmd_sel          = cmd_q;
        if (init_reg)
        begin
            cmd_sel          = '0;
            cmd_sel.req_type = REQ_CLEAR;
            cmd_sel.status   = ST_OK;
        end
    end

    cansig_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid || init_reg),
        .cmd_take  (q_take),
        .cmd       (cmd_sel),
        .rsp_valid (rsp_valid_int),
        .rsp_stall (rsp_stall && !drop_reg),
        .rsp       (rsp)
    );

    // Drop the result of the internal clear
    always_comb
    begin
        drop_next = drop_reg;
        if (init_reg)
        begin
            drop_next = 1'b1;
        end
        else if (drop_reg && rsp_valid_int)
        begin
            drop_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_reg <= 1'b0;
        end
        else
        begin
            drop_reg <= drop_next;
        end
    end

    assign rsp_valid = rsp_valid_int && !drop_reg;

endmodule

>>> verif/tb_can_signal_pack_unpack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_can_signal_pack_unpack: self-checking bench for CAN signal pack/unpack
// Drives directed and random requests, predicts each result from a local model
// of the payload store, and checks every result in order under random idling.
// ----------------------------------------------------------------------------
module tb_can_signal_pack_unpack;
    import cansig_pkg::*;

    class sig_scoreboard;
        logic [7:0] frame [64];
        rsp_t       pending [$];
        int         errors;

        function new();
            foreach (frame[k]) frame[k] = 8'h00;
            errors = 0;
        endfunction

        // Map absolute bit to byte, -1 when outside the frame
        function int byte_of(int pos, int start, logic order);
            int b;
            b = pos / 8;
            if (order) b = 2 * (start / 8) - b;
            if (b < 0 || b >= 64) return -1;
            return b;
        endfunction

        // Predict the result of one accepted request and update the store
        function void note_request(req_t r);
            rsp_t       e;
            int         start;
            int         len;
            logic       geom_ok;
            logic [63:0] raw;
            logic [63:0] lenmask;
            logic [63:0] wv;
            longint     sv;
            longint     hi;
            int         b;
            start = r.start_bit;
            len = r.bit_length;
            e.read_value = '0;
            e.status = ST_OK;
            raw = '0;
            if (r.req_type == REQ_LOAD_BYTE) begin
                frame[r.byte_index] = r.byte_value;
            end else if (r.req_type == REQ_READ_BYTE) begin
                e.read_value = {24'h0, frame[r.byte_index]};
            end else if (r.req_type == REQ_CLEAR) begin
                foreach (frame[k]) frame[k] = 8'h00;
            end else begin
                geom_ok = (len != 0 && len <= 32);
                for (int i = 0; i < len && geom_ok; i++)
                    if (byte_of(start + i, start, r.byte_order) < 0) geom_ok = 0;
                if (!geom_ok) begin
                    e.status = ST_RANGE;
                end else begin
                    lenmask = (64'd1 << len) - 1;
                    for (int i = 0; i < len; i++) begin
                        b = byte_of(start + i, start, r.byte_order);
                        raw[i] = frame[b][(start + i) % 8];
                    end
                    wv = {32'h0, r.write_value};
                    if (r.req_type == REQ_READ_U) begin
                        e.read_value = raw[31:0];
                    end else if (r.req_type == REQ_READ_S) begin
                        if (raw[len-1]) raw = raw | ~lenmask;
                        e.read_value = raw[31:0];
                    end else begin
                        if (r.req_type == REQ_WRITE_S) begin
                            sv = longint'($signed(r.write_value));
                            hi = (longint'(1) << (len - 1)) - 1;
                            if (sv > hi || sv < -hi - 1) e.status = ST_VALUE;
                            wv = sv & lenmask;
                        end else if (r.req_type == REQ_WRITE_F
                                     && r.write_value[30:23] == 8'hFF
                                     && r.write_value[22:0] != 0) begin
                            e.status = ST_VALUE;
                        end else if (wv > lenmask) begin
                            e.status = ST_VALUE;
                        end
                        if (e.status == ST_OK)
                            for (int i = 0; i < len; i++) begin
                                b = byte_of(start + i, start, r.byte_order);
                                frame[b][(start + i) % 8] = wv[i];
                            end
                    end
                end
            end
            pending.push_back(e);
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_result(rsp_t got);
            rsp_t e;
            if (pending.size() == 0) begin
                report("result with nothing expected");
                return;
            end
            e = pending.pop_front();
            if (got.read_value !== e.read_value)
                report($sformatf("read_value got %h exp %h", got.read_value, e.read_value));
            if (got.status !== e.status)
                report($sformatf("status got %0d exp %0d", got.status, e.status));
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 50) $display("MISMATCH @%0t: %s", $time, msg);
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_stall;
    req_t  req;
    logic  rsp_valid;
    logic  rsp_stall;
    rsp_t  rsp;

    sig_scoreboard sb;
    int    send_idle_pct;
    int    stall_pct;

    can_signal_pack_unpack i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Send one item, idling beforehand at the current rate
    task automatic send_item(req_t r);
        if ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sb.note_request(r);
    endtask

    // Drop valid and wait until every expected result has come
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    function automatic req_t make_req(logic [2:0] t, int sb_, int len, logic o,
                                      logic [31:0] wv);
        req_t r;
        r.req_type = t;
        r.start_bit = 9'(sb_);
        r.bit_length = 6'(len);
        r.byte_order = o;
        r.write_value = wv;
        r.byte_index = 6'($urandom);
        r.byte_value = 8'($urandom);
        return r;
    endfunction

    // Random request, mostly well-formed geometry
    function automatic req_t rand_req();
        req_t r;
        int   len;
        int   p;
        r = make_req(3'($urandom_range(7)), 0, 0, 1'($urandom_range(1)), $urandom);
        p = $urandom_range(99);
        if (p < 8) r.req_type = 3'(REQ_CLEAR + 3'($urandom_range(1)));
        if (r.req_type == REQ_CLEAR && $urandom_range(3) != 0)
            r.req_type = REQ_READ_U;
        len = (p < 85) ? $urandom_range(1, 32) : $urandom_range(0, 63);
        r.bit_length = 6'(len);
        if (p < 85) begin
            if (r.byte_order)
                r.start_bit = 9'($urandom_range(5 * 8, 511));
            else
                r.start_bit = 9'($urandom_range(0, 512 - (len == 0 ? 1 : len)));
        end else begin
            r.start_bit = 9'($urandom);
        end
        if ($urandom_range(1) && len > 0 && len < 32)
            r.write_value = $urandom & ((32'd1 << len) - 1);
        if (r.req_type == REQ_WRITE_S && $urandom_range(1) && len > 0)
            r.write_value = $signed($urandom) >>> (32 - len);
        if (r.req_type == REQ_WRITE_F && $urandom_range(3) == 0)
            r.write_value = {1'b0, 8'hFF, 23'($urandom_range(1, 3))} | ($urandom & 32'h8000_0000);
        return r;
    endfunction

    // Receiver: stall at random, check accepted results
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (rsp_valid && !rsp_stall) sb.check_result(rsp);
            rsp_stall <= ($urandom_range(99) < stall_pct);
        end else begin
            rsp_stall <= 1'b0;
        end
    end

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: byte access, extremes, both orders, each special case
        send_item(make_req(REQ_LOAD_BYTE, 0, 0, 0, 0));
        begin
            req_t r;
            r = make_req(REQ_LOAD_BYTE, 0, 0, 0, 0);
            r.byte_index = 6'd63; r.byte_value = 8'hA5; send_item(r);
            r.byte_index = 6'd0; r.byte_value = 8'hFF; send_item(r);
            r.req_type = REQ_READ_BYTE; send_item(r);
            r.byte_index = 6'd63; send_item(r);
        end
        send_item(make_req(REQ_READ_U, 0, 8, 0, 0));
        send_item(make_req(REQ_READ_S, 0, 8, 0, 0));
        send_item(make_req(REQ_WRITE_U, 0, 32, 0, 32'hFFFF_FFFF));
        send_item(make_req(REQ_READ_S, 0, 32, 0, 0));
        send_item(make_req(REQ_WRITE_U, 480, 32, 0, 32'h1234_5678));
        send_item(make_req(REQ_WRITE_U, 481, 32, 0, 0));
        send_item(make_req(REQ_READ_U, 0, 0, 0, 0));
        send_item(make_req(REQ_READ_U, 0, 33, 0, 0));
        send_item(make_req(REQ_WRITE_U, 3, 4, 0, 32'h10));
        send_item(make_req(REQ_WRITE_S, 100, 4, 1, 32'hFFFF_FFF8));
        send_item(make_req(REQ_WRITE_S, 100, 4, 1, 32'h8));
        send_item(make_req(REQ_WRITE_S, 200, 4, 0, 32'hFFFF_FFF7));
        send_item(make_req(REQ_READ_S, 100, 4, 1, 0));
        send_item(make_req(REQ_WRITE_F, 256, 32, 1, 32'h7FC0_0000));
        send_item(make_req(REQ_WRITE_F, 256, 32, 1, 32'h7F80_0000));
        send_item(make_req(REQ_READ_U, 256, 32, 1, 0));
        send_item(make_req(REQ_READ_U, 4, 16, 1, 0));
        send_item(make_req(REQ_READ_U, 511, 1, 1, 0));
        send_item(make_req(REQ_CLEAR, 0, 0, 0, 0));
        send_item(make_req(REQ_READ_U, 480, 32, 0, 0));

        // Random phases with different idling mixes
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 46; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 46; end
                3: begin send_idle_pct = 23; stall_pct = 23; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            for (int n = 0; n < 145; n++) begin
                send_item(rand_req());
                if (n == 70) wait_drained();
            end
        end

        stall_pct = 0;
        wait_drained();
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
